/* rtl/clrs_pkg.sv */
// Package for the cosine learning-rate schedule: widths, codes, the shared
// divider stage type and the elaboration-time cosine weight table.
// Depends on nothing.
`default_nettype none

package clrs_pkg;

  localparam int COS_TABLE_BITS = 10;
  localparam int STEP_WIDTH     = 32;

  localparam int DATA_W     = 32;
  localparam int FLOOR_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_STAGES = 32;
  localparam int W_W        = 33;
  localparam int COS_DEPTH  = (1 << COS_TABLE_BITS) + 1;
  localparam int COS_ADDR_W = COS_TABLE_BITS + 1;

  localparam logic [DATA_W-1:0] STEP_MASK =
    (STEP_WIDTH >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << STEP_WIDTH) - 64'd1);

  localparam logic [DATA_W-1:0]  BASE_RATE_RST = 32'd1288490;
  localparam logic [FLOOR_W-1:0] RATIO_ONE     = 17'h10000;
  localparam logic [63:0]        Q30_ONE       = 64'd1073741824;
  localparam logic [63:0]        HALF_PI_Q30   = 64'd1686629713;

  typedef enum logic [1:0] {
    PH_WARMUP = 2'd0,
    PH_DECAY  = 2'd1,
    PH_PAST   = 2'd2,
    PH_CONST  = 2'd3
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_RATE    = 2'd0,
    CFG_WARMUP_STEPS = 2'd1,
    CFG_TOTAL_STEPS  = 2'd2,
    CFG_FLOOR_RATIO  = 2'd3
  } cfg_idx_e;

  // One slice of the restoring divider: partial remainder, dividend bits
  // that turn into quotient bits, and the divisor.
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] dvs;
  } div_t;

  typedef logic [W_W-1:0] cos_lut_t [COS_DEPTH];

  // 0.5 * (1 + cos(pi * idx / 2^B)) in Q0.32 through a Horner Taylor series.
  function automatic logic [W_W-1:0] cos_weight(int unsigned idx);
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] t;
    a  = (64'(idx) * HALF_PI_Q30) >> COS_TABLE_BITS;
    x2 = (a * a) >> 30;
    h  = Q30_ONE;
    t  = ((x2 * h) >> 30) / 64'd182;
    h  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * h) >> 30) / 64'd132;
    h  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * h) >> 30) / 64'd90;
    h  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * h) >> 30) / 64'd56;
    h  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * h) >> 30) / 64'd30;
    h  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * h) >> 30) / 64'd12;
    h  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * h) >> 30) / 64'd2;
    h  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    return W_W'((h * h) >> 28);
  endfunction

  function automatic cos_lut_t build_cos_lut();
    cos_lut_t lut;
    for (int i = 0; i < COS_DEPTH; i++) begin
      lut[i] = cos_weight(i);
    end
    return lut;
  endfunction

endpackage

`default_nettype wire

/* rtl/clrs_if.sv */
// Valid/ready channel interfaces for step numbers in and rates out.
// Depends on clrs_pkg for the field widths.
`default_nettype none

interface clrs_step_if;
  logic                        valid;
  logic                        ready;
  logic [clrs_pkg::DATA_W-1:0] step_number;

  modport source (output valid, output step_number, input ready);
  modport sink   (input valid, input step_number, output ready);
endinterface

interface clrs_rate_if;
  logic                        valid;
  logic                        ready;
  logic [clrs_pkg::DATA_W-1:0] rate;
  logic [1:0]                  phase;

  modport source (output valid, output rate, output phase, input ready);
  modport sink   (input valid, input rate, input phase, output ready);
endinterface

`default_nettype wire

/* rtl/cosine_learning_rate_schedule.sv */
// Top level of the cosine learning-rate schedule with linear warmup.
// Depends on clrs_pkg, clrs_if, clrs_div_step and clrs_cos_rom.
//
//   channel   direction  transaction payload        handshake
//   step_i    in         step_number[31:0]          valid / ready
//   rate_o    out        rate[31:0], phase[1:0]     valid / ready
//   cfg       in         cfg_idx_i, cfg_data_i      cfg_we_i, no back-pressure
//
// One transaction enters per cycle while the output is not stalled.
// The pipeline is the 32-stage restoring divider that serves both the
// warmup ramp and the cosine progress index, plus input, ROM, two multiply
// and output stages. Reset clears all valid bits and restores the register
// defaults. A stall on the output freezes the whole pipeline; a one-entry
// skid buffer at the input takes a transaction while the result waits.
`default_nettype none

module cosine_learning_rate_schedule (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [clrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [clrs_pkg::DATA_W-1:0]    cfg_data_i,
  clrs_step_if.sink                      step_i,
  clrs_rate_if.source                    rate_o
);
  import clrs_pkg::*;

  // Configuration registers. The user must change them only while the pipeline
  // is empty; the block does not enforce this. Every stage reads them directly.
  logic [DATA_W-1:0]  base_q;
  logic [DATA_W-1:0]  warmup_q;
  logic [DATA_W-1:0]  total_q;
  logic [FLOOR_W-1:0] floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_RATE_RST;
      warmup_q <= '0;
      total_q  <= '0;
      floor_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_RATE:    base_q   <= cfg_data_i;
        CFG_WARMUP_STEPS: warmup_q <= cfg_data_i;
        CFG_TOTAL_STEPS:  total_q  <= cfg_data_i;
        CFG_FLOOR_RATIO:  floor_q  <= cfg_data_i[FLOOR_W-1:0];
      endcase
    end
  end

  // The whole pipeline advances when the output register is free or taken.
  logic en;
  logic out_vld_q;

  assign en = !out_vld_q || rate_o.ready;

  // Input skid buffer. It fills only when a transaction arrives during a stall.
  logic              skid_vld_q;
  logic [DATA_W-1:0] skid_step_q;
  logic              in_vld;
  logic [DATA_W-1:0] in_step;

  assign step_i.ready = !skid_vld_q;
  assign in_vld       = skid_vld_q || step_i.valid;
  assign in_step      = (skid_vld_q ? skid_step_q : step_i.step_number) & STEP_MASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en) begin
      skid_vld_q <= 1'b0;
    end else if (step_i.valid) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      skid_step_q <= step_i.step_number;
    end
  end

  // Stage 0: classify the step and set up the division. During warmup the
  // dividend is base_rate * (step + 1) over warmup_steps. During decay the
  // dividend is (step - warmup) * 2^32 over the decay length, whose top
  // quotient bits are the cosine table index.
  logic              warm;
  logic              no_window;
  logic [64:0]       ramp_prod;
  logic [DATA_W-1:0] decay_len;
  logic [DATA_W-1:0] decay_pos;
  phase_e            ph0_d;

  assign warm      = (warmup_q != '0) && (in_step < warmup_q);
  assign no_window = (total_q <= warmup_q);
  assign ramp_prod = {33'd0, base_q} * {32'd0, ({1'b0, in_step} + 33'd1)};
  assign decay_len = total_q - warmup_q;
  assign decay_pos = in_step - warmup_q;

  always_comb begin
    priority if (warm) begin
      ph0_d = PH_WARMUP;
    end else if (no_window) begin
      ph0_d = PH_CONST;
    end else if (in_step < total_q) begin
      ph0_d = PH_DECAY;
    end else begin
      ph0_d = PH_PAST;
    end
  end

  logic [DIV_STAGES:0] dvld_q;
  phase_e              dph_q [DIV_STAGES+1];
  div_t                div_q [DIV_STAGES+1];
  div_t                div_d [DIV_STAGES+1];

  always_comb begin
    if (warm) begin
      div_d[0].rem = ramp_prod[63:32];
      div_d[0].quo = ramp_prod[31:0];
      div_d[0].dvs = warmup_q;
    end else begin
      div_d[0].rem = decay_pos;
      div_d[0].quo = '0;
      div_d[0].dvs = decay_len;
    end
  end

  // Stages 1 to 32: one quotient bit per stage.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    clrs_div_step u_step (
      .d_i (div_q[k]),
      .d_o (div_d[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
    end else if (en) begin
      dvld_q <= {dvld_q[DIV_STAGES-1:0], in_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dph_q[0] <= ph0_d;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        div_q[k] <= div_d[k];
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        dph_q[k] <= dph_q[k-1];
      end
    end
  end

  // ROM stage: past the end of the decay the index is pinned at the table end.
  logic [DATA_W-1:0]     quo_last;
  logic [COS_ADDR_W-1:0] rom_addr;
  logic [W_W-1:0]        weight;
  logic                  rvld_q;
  phase_e                rph_q;
  logic [DATA_W-1:0]     rquo_q;

  assign quo_last = div_q[DIV_STAGES].quo;
  assign rom_addr = (dph_q[DIV_STAGES] == PH_PAST) ? COS_ADDR_W'(1 << COS_TABLE_BITS)
                                                   : {1'b0, quo_last[DATA_W-1 -: COS_TABLE_BITS]};

  clrs_cos_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (en),
    .addr_i (rom_addr),
    .data_o (weight)
  );

  // Mix stage: blend the floor ratio with the cosine weight.
  logic [FLOOR_W-1:0] ratio;
  logic [49:0]        span_prod;
  logic [W_W-1:0]     mix_d;
  logic [W_W-1:0]     mix_q;
  logic               mvld_q;
  phase_e             mph_q;
  logic [DATA_W-1:0]  mquo_q;

  assign ratio     = (floor_q > RATIO_ONE) ? RATIO_ONE : floor_q;
  assign span_prod = {33'd0, RATIO_ONE - ratio} * {17'd0, weight};
  assign mix_d     = {ratio, 16'd0} + W_W'(span_prod >> 16);

  // Scale stage: apply the blend to the peak rate.
  logic [64:0]       scale_prod;
  logic [W_W-1:0]    scaled_q;
  logic              svld_q;
  phase_e            sph_q;
  logic [DATA_W-1:0] squo_q;

  assign scale_prod = {33'd0, base_q} * {32'd0, mix_q};

  // Output stage: pick the result by phase and saturate.
  logic [DATA_W-1:0] rate_d;
  logic [DATA_W-1:0] rate_q;
  phase_e            phase_q;

  always_comb begin
    unique case (sph_q)
      PH_WARMUP: rate_d = squo_q;
      PH_CONST:  rate_d = base_q;
      PH_DECAY,
      PH_PAST:   rate_d = scaled_q[W_W-1] ? {DATA_W{1'b1}} : scaled_q[DATA_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q    <= 1'b0;
      mvld_q    <= 1'b0;
      svld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      rvld_q    <= dvld_q[DIV_STAGES];
      mvld_q    <= rvld_q;
      svld_q    <= mvld_q;
      out_vld_q <= svld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rph_q    <= dph_q[DIV_STAGES];
      rquo_q   <= quo_last;
      mix_q    <= mix_d;
      mph_q    <= rph_q;
      mquo_q   <= rquo_q;
      scaled_q <= scale_prod[64:32];
      sph_q    <= mph_q;
      squo_q   <= mquo_q;
      rate_q   <= rate_d;
      phase_q  <= sph_q;
    end
  end

  assign rate_o.valid = out_vld_q;
  assign rate_o.rate  = rate_q;
  assign rate_o.phase = phase_q;

endmodule

`default_nettype wire

/* rtl/clrs_div_step.sv */
// One radix-2 restoring division step: shifts in a dividend bit and
// produces one quotient bit. Depends on clrs_pkg for div_t.
`default_nettype none

module clrs_div_step (
  input  clrs_pkg::div_t d_i,
  output clrs_pkg::div_t d_o
);
  import clrs_pkg::*;

  logic [DATA_W:0] trial;
  logic [DATA_W:0] diff;
  logic            ge;

  assign trial = {d_i.rem, d_i.quo[DATA_W-1]};
  assign diff  = trial - {1'b0, d_i.dvs};
  assign ge    = (trial >= {1'b0, d_i.dvs});

  // The remainder stays below the divisor, so the difference fits the width.
  assign d_o.rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
  assign d_o.quo = {d_i.quo[DATA_W-2:0], ge};
  assign d_o.dvs = d_i.dvs;

endmodule

`default_nettype wire

/* rtl/clrs_cos_rom.sv */
// Cosine weight ROM with a registered read port, filled at elaboration.
// Depends on clrs_pkg for the table builder and widths.
`default_nettype none

module clrs_cos_rom (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [clrs_pkg::COS_ADDR_W-1:0] addr_i,
  output logic [clrs_pkg::W_W-1:0]        data_o
);
  import clrs_pkg::*;

  localparam cos_lut_t Lut = build_cos_lut();

  logic [W_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= Lut[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* rtl/clrs_checker.sv */
// Port-level checker for the cosine learning-rate schedule and its bind.
// Depends on clrs_pkg and the top level's ports.
`default_nettype none

module clrs_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [clrs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [clrs_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                           in_ready_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [clrs_pkg::DATA_W-1:0]    rate_i,
  input  logic [1:0]                     phase_i
);
  import clrs_pkg::*;

  logic [DATA_W-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RATE_RST;
    end else if (cfg_we_i && (cfg_idx_i == CFG_BASE_RATE)) begin
      base_q <= cfg_data_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rate_i) && $stable(phase_i))
    else $error("result changed while stalled");

  a_rate_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> rate_i <= base_q)
    else $error("rate above the peak rate");

  a_const_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (phase_i == PH_CONST) |-> rate_i == base_q)
    else $error("constant phase does not give the peak rate");

  a_skid_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input back-pressure without an output stall");

endmodule

bind cosine_learning_rate_schedule clrs_checker u_clrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i),
  .in_ready_i  (step_i.ready),
  .out_valid_i (rate_o.valid),
  .out_ready_i (rate_o.ready),
  .rate_i      (rate_o.rate),
  .phase_i     (rate_o.phase)
);

`default_nettype wire

/* dv/tb_cosine_learning_rate_schedule.sv */
// Testbench for the cosine learning-rate schedule: directed table plus random
// steps under several register settings, checked against a local predictor.
// Depends on clrs_pkg, clrs_if and the cosine_learning_rate_schedule RTL.
`default_nettype none

module tb_cosine_learning_rate_schedule;
  timeunit 1ns;
  timeprecision 1ps;
  import clrs_pkg::*;

  localparam int LATENCY     = 37;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;

  clrs_step_if step_if ();
  clrs_rate_if rate_if ();

  cosine_learning_rate_schedule u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step_if.sink),
    .rate_o     (rate_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the schedule registers used by the predictor.
  logic [31:0] sh_base = BASE_RATE_RST;
  logic [31:0] sh_warm = '0;
  logic [31:0] sh_total = '0;
  logic [16:0] sh_floor = '0;

  typedef struct packed {
    logic [31:0] rate;
    phase_e      phase;
  } lr_t;

  lr_t         pending_rates[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycles = 0;
  bit          sink_idle_en = 1'b1;
  bit          src_idle_en = 1'b1;
  bit          hold_sink = 1'b0;
  int unsigned phase_hits[4] = '{0, 0, 0, 0};

  // Half-cosine weight in Q0.32, Horner evaluation of the Taylor series.
  function automatic logic [63:0] half_cos_q32(logic [63:0] idx);
    logic [63:0] ang, sq, acc, t;
    logic [63:0] divs[7];
    divs = '{64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};
    ang = (idx * HALF_PI_Q30) >> COS_TABLE_BITS;
    sq  = (ang * ang) >> 30;
    acc = Q30_ONE;
    for (int k = 0; k < 7; k++) begin
      t   = ((sq * acc) >> 30) / divs[k];
      acc = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    end
    return (acc * acc) >> 28;
  endfunction

  function automatic lr_t schedule_rate(logic [31:0] step_in);
    lr_t res;
    logic [63:0] st, rt, idx, r, w, mult;
    st = 64'(step_in & STEP_MASK);
    if (sh_warm != 0 && st < 64'(sh_warm)) begin
      rt = (64'(sh_base) * (st + 64'd1)) / 64'(sh_warm);
      res.phase = PH_WARMUP;
    end else if (sh_total <= sh_warm) begin
      rt = 64'(sh_base);
      res.phase = PH_CONST;
    end else begin
      if (st < 64'(sh_total)) begin
        idx = ((st - 64'(sh_warm)) << COS_TABLE_BITS) / 64'(sh_total - sh_warm);
        res.phase = PH_DECAY;
      end else begin
        idx = 64'd1 << COS_TABLE_BITS;
        res.phase = PH_PAST;
      end
      r = (sh_floor > RATIO_ONE) ? 64'(RATIO_ONE) : 64'(sh_floor);
      w = half_cos_q32(idx);
      mult = (r << 16) + (((64'(RATIO_ONE) - r) * w) >> 16);
      rt = (64'(sh_base) * mult) >> 32;
    end
    res.rate = (rt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rt[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got 0x%08h expected 0x%08h (result %0d)",
             what, got, want, results_seen);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BASE_RATE:    sh_base = val;
      CFG_WARMUP_STEPS: sh_warm = val;
      CFG_TOTAL_STEPS:  sh_total = val;
      default:          sh_floor = val[16:0];
    endcase
  endtask

  task automatic write_schedule(logic [31:0] b, logic [31:0] wu, logic [31:0] tot,
                                logic [31:0] fl);
    write_reg(CFG_BASE_RATE, b);
    write_reg(CFG_WARMUP_STEPS, wu);
    write_reg(CFG_TOTAL_STEPS, tot);
    write_reg(CFG_FLOOR_RATIO, fl);
  endtask

  // Every accepted transaction leaves exactly one result, so draining
  // the queue means the pipeline is empty.
  task automatic drain();
    while (pending_rates.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Offers one step and holds it until the block accepts the transaction.
  task automatic send_step(logic [31:0] st, bit idle_ok);
    if (idle_ok && src_idle_en) begin
      while ($urandom_range(99) < 36) begin
        step_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    step_if.valid       <= 1'b1;
    step_if.step_number <= st;
    @(posedge clk_i);
    while (!step_if.ready) @(posedge clk_i);
    pending_rates.insert(pending_rates.size(), schedule_rate(st));
  endtask

  task automatic idle_source();
    step_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Biased random step: near the warmup and total boundaries, anywhere, or at most total + 16.
  function automatic logic [31:0] pick_step();
    case ($urandom_range(5))
      0: return sh_warm + $urandom_range(4) - 2;
      1: return sh_total + $urandom_range(4) - 2;
      2: return $urandom;
      default: return $urandom_range(sh_total + 16);
    endcase
  endfunction

  // Directed rows: schedule registers, step, and for a few rows the result.
  typedef struct {
    logic [31:0] base, warm, total, floor, step;
    bit          known;
    logic [31:0] rate;
    phase_e      phase;
  } row_t;

  row_t dir_rows[] = '{
    // Reset defaults: no decay window, the base rate comes out unchanged.
    '{32'd1288490, 0, 0, 0, 32'd0, 1, 32'd1288490, PH_CONST},
    '{32'd1288490, 0, 0, 0, 32'hFFFF_FFFF, 1, 32'd1288490, PH_CONST},
    // Warmup ramp, including its first and last step, then steps in the decay.
    '{32'd1000, 10, 100, 0, 32'd0, 1, 32'd100, PH_WARMUP},
    '{32'd1000, 10, 100, 0, 32'd9, 1, 32'd1000, PH_WARMUP},
    '{32'd1000, 10, 100, 0, 32'd10, 0, 0, PH_DECAY},
    '{32'd1000, 10, 100, 0, 32'd55, 0, 0, PH_DECAY},
    '{32'd1000, 10, 100, 0, 32'd99, 0, 0, PH_DECAY},
    // Past the total, weight is zero so only the floor remains.
    '{32'd1000, 10, 100, 0, 32'd100, 1, 32'd0, PH_PAST},
    '{32'd1000, 10, 100, 0, 32'hFFFF_FFFF, 1, 32'd0, PH_PAST},
    // Floor ratio of one and above one both keep the full base rate.
    '{32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'h10000, 32'd12345, 0, 0, PH_DECAY},
    '{32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'h1FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF,
      PH_PAST},
    '{32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'h1FFFF, 32'd0, 0, 0, PH_DECAY},
    // Largest warmup with the largest step still inside it.
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000, 32'hFFFF_FFFE, 1,
      32'hFFFF_FFFF, PH_WARMUP},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000, 32'hFFFF_FFFF, 1,
      32'hFFFF_FFFF, PH_CONST},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000, 32'd0, 0, 0, PH_WARMUP},
    // Total below warmup: constant once warmup ends.
    '{32'd5000, 20, 5, 0, 32'd20, 1, 32'd5000, PH_CONST},
    '{32'd5000, 20, 5, 0, 32'd3, 0, 0, PH_WARMUP},
    // Decay window of one step, and zero base rate.
    '{32'h8000_0000, 7, 8, 32'h4000, 32'd7, 0, 0, PH_DECAY},
    '{32'h8000_0000, 7, 8, 32'h4000, 32'd8, 0, 0, PH_PAST},
    '{32'd0, 0, 32'd1000, 32'h4000, 32'd500, 1, 32'd0, PH_DECAY},
    '{32'h7FFF_FFFF, 0, 32'h0000_0400, 32'h5555, 32'h0000_0200, 0, 0, PH_DECAY}
  };

  // Checks each result transaction against the oldest predicted rate.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && rate_if.valid && rate_if.ready) begin
      if (pending_rates.size() == 0) begin
        report_mismatch("unexpected result", rate_if.rate, 32'd0);
      end else begin
        lr_t want;
        want = pending_rates.pop_front();
        if (rate_if.rate !== want.rate) report_mismatch("rate", rate_if.rate, want.rate);
        if (rate_if.phase !== want.phase)
          report_mismatch("phase", 32'(rate_if.phase), 32'(want.phase));
        phase_hits[want.phase]++;
      end
      results_seen <= results_seen + 1;
    end
  end

  // Result-side back-pressure: random stalls, or a long forced hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) rate_if.ready <= 1'b0;
    else if (hold_sink) rate_if.ready <= 1'b0;
    else if (sink_idle_en) rate_if.ready <= ($urandom_range(99) >= 36);
    else rate_if.ready <= 1'b1;
  end

  // Long receiver stall counted in its own process while the sender keeps going.
  task automatic stall_receiver(int n);
    hold_sink = 1'b1;
    repeat (n) @(posedge clk_i);
    hold_sink = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_rates.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    lr_t want;
    step_if.valid       = 1'b0;
    step_if.step_number = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; registers change only with the pipeline empty.
    foreach (dir_rows[i]) begin
      if (i == 0 || dir_rows[i].base != sh_base || dir_rows[i].warm != sh_warm ||
          dir_rows[i].total != sh_total || dir_rows[i].floor[16:0] != sh_floor) begin
        idle_source();
        drain();
        write_schedule(dir_rows[i].base, dir_rows[i].warm, dir_rows[i].total,
                       dir_rows[i].floor);
      end
      if (dir_rows[i].known) begin
        want = schedule_rate(dir_rows[i].step);
        if (want.rate !== dir_rows[i].rate || want.phase !== dir_rows[i].phase)
          report_mismatch("table row", want.rate, dir_rows[i].rate);
      end
      send_step(dir_rows[i].step, 1'b1);
    end
    idle_source();
    drain();

    // Random phases, each with fresh registers; several use extreme values.
    for (int ph = 0; ph < 11; ph++) begin
      logic [31:0] wu, tot;
      wu  = (ph % 3 == 0) ? 32'd0 : $urandom_range(ph < 8 ? 300 : 32'hFFFF);
      tot = (ph == 4) ? wu : wu + $urandom_range(ph < 8 ? 3000 : 32'hFFFFF);
      if (ph == 9) begin
        wu = $urandom;
        tot = $urandom;
      end
      write_schedule((ph == 1) ? 32'hFFFF_FFFF : $urandom,
                     wu, tot,
                     (ph == 2) ? 32'h10000 : (ph == 5) ? 32'h1FFFF : $urandom_range(32'h1FFFF));
      src_idle_en  = (ph != 3);
      sink_idle_en = (ph != 3);
      if (ph == 6) fork stall_receiver(150); join_none
      for (int n = 0; n < 48; n++) send_step(pick_step(), 1'b1);
      // The sender waits here until every expected rate is back.
      idle_source();
      drain();
    end

    repeat (LATENCY + 5) @(posedge clk_i);
    $display("Covered %0d results: warmup %0d, decay %0d, past total %0d, constant %0d.",
             results_seen, phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3]);
    $display("Register settings included zero and full-scale base, warmup and total.");
    if (mismatches == 0 && pending_rates.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* cosine_learning_rate_schedule.f */
rtl/clrs_pkg.sv
rtl/clrs_if.sv
rtl/clrs_div_step.sv
rtl/clrs_cos_rom.sv
rtl/cosine_learning_rate_schedule.sv
rtl/clrs_checker.sv
dv/tb_cosine_learning_rate_schedule.sv
